/* rtl/zasp_pkg.sv */
// Shared types, codes and helpers of the ZIP archive record parser.
`timescale 1ns / 1ps
package zasp_pkg;

  // Record signatures and header constants
  localparam logic [31:0] SigLocal      = 32'h0403_4b50;
  localparam logic [31:0] SigCentral    = 32'h0201_4b50;
  localparam logic [31:0] SigEnd        = 32'h0605_4b50;
  localparam int unsigned FlagDescBit   = 3;
  localparam logic [15:0] MethodStored  = 16'd0;
  localparam logic [15:0] MethodDeflate = 16'd8;
  localparam logic [31:0] CrcPoly       = 32'hEDB8_8320;

  // Header lengths in bytes
  localparam logic [5:0] SigLen   = 6'd4;
  localparam logic [5:0] LhdrLen  = 6'd26;
  localparam logic [5:0] DescLen  = 6'd12;
  localparam logic [5:0] ChdrLen  = 6'd42;
  localparam logic [5:0] EhdrLen  = 6'd18;

  // Phase codes, also reported as byte class
  localparam logic [3:0] PhSig     = 4'd0;
  localparam logic [3:0] PhLhdr    = 4'd1;
  localparam logic [3:0] PhName    = 4'd2;
  localparam logic [3:0] PhExtra   = 4'd3;
  localparam logic [3:0] PhPayload = 4'd4;
  localparam logic [3:0] PhDesc    = 4'd5;
  localparam logic [3:0] PhChdr    = 4'd6;
  localparam logic [3:0] PhCskip   = 4'd7;
  localparam logic [3:0] PhEhdr    = 4'd8;
  localparam logic [3:0] PhComment = 4'd9;
  localparam logic [3:0] PhHalted  = 4'd10;

  // Status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadSig   = 2'd1;
  localparam logic [1:0] StBadMeth  = 2'd2;
  localparam logic [1:0] StCrcError = 2'd3;

  // Configuration register indexes
  localparam logic CfgDeflatePass = 1'b0;
  localparam logic CfgCrcEnable   = 1'b1;

  // Default queue depths
  localparam int unsigned InQueueDepth  = 2;
  localparam int unsigned OutQueueDepth = 2;

  // One result beat
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_class;
    logic        header_done;
    logic        entry_end;
    logic        is_compressed;
    logic [31:0] uncompressed_size;
    logic [1:0]  status;
  } result_t;

  // Handshake between a queue and the parser core
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/zasp_fifo.sv */
// Small register queue that decouples the parser core from its neighbors.
`timescale 1ns / 1ps
module zasp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output zasp_pkg::queue_status_t status_o
);
  import zasp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full      = (cnt_q == FullCnt);
  assign status_o.not_empty = (cnt_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/zasp_engine.sv */
// Framing core: walks signatures, headers, sections one byte per unstalled cycle.
`timescale 1ns / 1ps
module zasp_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic                    cfg_data_i,
  input  zasp_pkg::queue_status_t in_status_i,
  input  logic [7:0]              in_byte_i,
  output logic                    in_pop_o,
  input  zasp_pkg::queue_status_t out_status_i,
  output logic                    out_push_o,
  output zasp_pkg::result_t       result_o
);
  import zasp_pkg::*;

  logic        deflate_pass_q, crc_en_q;
  logic [3:0]  phase_q, phase_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  off_q, off_d, off_inc;
  logic [31:0] sig_q, sig_d;
  logic        desc_flag_q, desc_flag_d;
  logic [15:0] method_q, method_d;
  logic [31:0] exp_crc_q, exp_crc_d;
  logic [31:0] csize_q, csize_d;
  logic [31:0] plain_q, plain_d;
  logic [15:0] name_bytes_q, name_bytes_d;
  logic [15:0] extra_bytes_q, extra_bytes_d;
  logic [31:0] crc_q, crc_d;
  logic [1:0]  halt_q, halt_d;

  logic        take;
  logic [7:0]  b;
  logic [3:0]  cls;
  logic        hdr_done, pulse_end;
  logic [1:0]  st;
  logic        go_name, go_extra, go_pay;
  logic        crc_bad;

  assign take       = in_status_i.not_empty && !out_status_i.full;
  assign in_pop_o   = take;
  assign out_push_o = take;
  assign b          = in_byte_i;
  assign off_inc    = off_q + 6'd1;

  // Step the record walker over one byte
  always_comb begin
    phase_d       = phase_q;
    rem_d         = rem_q;
    off_d         = off_q;
    sig_d         = sig_q;
    desc_flag_d   = desc_flag_q;
    method_d      = method_q;
    exp_crc_d     = exp_crc_q;
    csize_d       = csize_q;
    plain_d       = plain_q;
    name_bytes_d  = name_bytes_q;
    extra_bytes_d = extra_bytes_q;
    crc_d         = crc_q;
    halt_d        = halt_q;
    cls           = (phase_q > PhHalted) ? PhHalted : phase_q;
    hdr_done      = 1'b0;
    pulse_end     = 1'b0;
    st            = StOk;
    go_name       = 1'b0;
    go_extra      = 1'b0;
    go_pay        = 1'b0;
    crc_bad       = 1'b0;

    unique case (phase_q)
      PhSig: begin
        sig_d = {b, sig_q[31:8]};
        off_d = off_inc;
        if (off_inc >= SigLen) begin
          off_d = '0;
          if (sig_d == SigLocal) begin
            phase_d = PhLhdr;
          end else if (sig_d == SigCentral) begin
            phase_d = PhChdr;
          end else if (sig_d == SigEnd) begin
            phase_d = PhEhdr;
          end else begin
            phase_d = PhHalted;
            halt_d  = StBadSig;
            st      = StBadSig;
          end
        end
      end
      PhLhdr: begin
        // Capture header fields, little-endian
        unique case (off_q)
          6'd2:    desc_flag_d         = b[FlagDescBit];
          6'd4:    method_d[7:0]       = b;
          6'd5:    method_d[15:8]      = b;
          6'd10:   exp_crc_d[7:0]      = b;
          6'd11:   exp_crc_d[15:8]     = b;
          6'd12:   exp_crc_d[23:16]    = b;
          6'd13:   exp_crc_d[31:24]    = b;
          6'd14:   csize_d[7:0]        = b;
          6'd15:   csize_d[15:8]       = b;
          6'd16:   csize_d[23:16]      = b;
          6'd17:   csize_d[31:24]      = b;
          6'd18:   plain_d[7:0]        = b;
          6'd19:   plain_d[15:8]       = b;
          6'd20:   plain_d[23:16]      = b;
          6'd21:   plain_d[31:24]      = b;
          6'd22:   name_bytes_d[7:0]   = b;
          6'd23:   name_bytes_d[15:8]  = b;
          6'd24:   extra_bytes_d[7:0]  = b;
          6'd25:   extra_bytes_d[15:8] = b;
          default: ;
        endcase
        off_d = off_inc;
        if (off_inc >= LhdrLen) begin
          off_d    = '0;
          hdr_done = 1'b1;
          crc_d    = '1;
          if (method_d == MethodStored ||
              (method_d == MethodDeflate && deflate_pass_q)) begin
            if (name_bytes_d != '0) begin
              phase_d = PhName;
              rem_d   = {16'd0, name_bytes_d};
            end else begin
              go_name = 1'b1;
            end
          end else begin
            phase_d = PhHalted;
            halt_d  = StBadMeth;
            st      = StBadMeth;
          end
        end
      end
      PhName: begin
        rem_d = rem_q - 32'd1;
        go_name = (rem_d == '0);
      end
      PhExtra: begin
        rem_d = rem_q - 32'd1;
        go_extra = (rem_d == '0);
      end
      PhPayload: begin
        if (method_q == MethodStored) begin
          crc_d = crc32_byte(crc_q, b);
        end
        rem_d  = rem_q - 32'd1;
        go_pay = (rem_d == '0);
      end
      PhDesc: begin
        unique case (off_q)
          6'd0:    exp_crc_d[7:0]   = b;
          6'd1:    exp_crc_d[15:8]  = b;
          6'd2:    exp_crc_d[23:16] = b;
          6'd3:    exp_crc_d[31:24] = b;
          default: ;
        endcase
        off_d = off_inc;
        if (off_inc >= DescLen) begin
          if (method_d == MethodStored && crc_en_q && (~crc_d != exp_crc_d)) begin
            phase_d = PhHalted;
            halt_d  = StCrcError;
            st      = StCrcError;
          end else begin
            pulse_end = 1'b1;
            phase_d   = PhSig;
            off_d     = '0;
          end
        end
      end
      PhChdr: begin
        // Sum name, extra and comment lengths
        if (off_q >= 6'd24 && off_q <= 6'd29) begin
          rem_d = ((off_q == 6'd24) ? 32'd0 : rem_q) +
                  (off_q[0] ? {16'd0, b, 8'd0} : {24'd0, b});
        end
        off_d = off_inc;
        if (off_inc >= ChdrLen) begin
          phase_d = (rem_d != '0) ? PhCskip : PhSig;
          off_d   = '0;
        end
      end
      PhEhdr: begin
        if (off_q == 6'd16) begin
          rem_d = {24'd0, b};
        end else if (off_q == 6'd17) begin
          rem_d = rem_q | {16'd0, b, 8'd0};
        end
        off_d = off_inc;
        if (off_inc >= EhdrLen) begin
          phase_d = (rem_d != '0) ? PhComment : PhSig;
          off_d   = '0;
        end
      end
      PhCskip, PhComment: begin
        rem_d = rem_q - 32'd1;
        if (rem_d == '0) begin
          phase_d = PhSig;
          off_d   = '0;
        end
      end
      default: begin
        cls     = PhHalted;
        phase_d = PhHalted;
        st      = halt_q;
      end
    endcase

    // Pass over empty sections
    if (go_name) begin
      if (extra_bytes_d != '0) begin
        phase_d = PhExtra;
        rem_d   = {16'd0, extra_bytes_d};
      end else begin
        go_extra = 1'b1;
      end
    end
    if (go_extra) begin
      if (csize_d != '0) begin
        phase_d = PhPayload;
        rem_d   = csize_d;
      end else begin
        go_pay = 1'b1;
      end
    end
    if (go_pay) begin
      crc_bad = (method_d == MethodStored) && crc_en_q && (~crc_d != exp_crc_d);
      if (desc_flag_d) begin
        phase_d = PhDesc;
        off_d   = '0;
      end else if (crc_bad) begin
        phase_d = PhHalted;
        halt_d  = StCrcError;
        st      = StCrcError;
      end else begin
        pulse_end = 1'b1;
        phase_d   = PhSig;
        off_d     = '0;
      end
    end
  end

  // Drive the result beat
  always_comb begin
    result_o.byte_out          = b;
    result_o.byte_class        = cls;
    result_o.header_done       = hdr_done;
    result_o.entry_end         = pulse_end;
    result_o.is_compressed     = (method_d == MethodDeflate);
    result_o.uncompressed_size = plain_d;
    result_o.status            = st;
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deflate_pass_q <= 1'b1;
      crc_en_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDeflatePass: deflate_pass_q <= cfg_data_i;
        CfgCrcEnable:   crc_en_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance walker state on each taken beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSig;
      rem_q         <= '0;
      off_q         <= '0;
      sig_q         <= '0;
      desc_flag_q   <= 1'b0;
      method_q      <= '0;
      exp_crc_q     <= '0;
      csize_q       <= '0;
      plain_q       <= '0;
      name_bytes_q  <= '0;
      extra_bytes_q <= '0;
      crc_q         <= '1;
      halt_q        <= StOk;
    end else if (take) begin
      phase_q       <= phase_d;
      rem_q         <= rem_d;
      off_q         <= off_d;
      sig_q         <= sig_d;
      desc_flag_q   <= desc_flag_d;
      method_q      <= method_d;
      exp_crc_q     <= exp_crc_d;
      csize_q       <= csize_d;
      plain_q       <= plain_d;
      name_bytes_q  <= name_bytes_d;
      extra_bytes_q <= extra_bytes_d;
      crc_q         <= crc_d;
      halt_q        <= halt_d;
    end
  end

endmodule

/* rtl/zip_archive_stream_parser.sv */
// Top level of the ZIP archive record parser: input queue, framing core, result queue.
//
//  channel   direction  handshake                 beat
//  input     in         push / full               data_byte_i
//  result    out        empty / pop               byte_out_o .. status_o
//  config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One archive byte per cycle: the core takes a byte from the input queue in
// every cycle in which it holds one and the result queue has room. A pushed
// byte is held in the input queue; when the core takes it, its result is written
// into the result queue, whose head drives the result ports until it is popped.
// Reset returns the walker to signature search and both registers to 1.
// A stalled result side fills the result queue, then the input queue, then full
// rises; either side may stall independently of the other.
`timescale 1ns / 1ps
module zip_archive_stream_parser #(
  parameter int unsigned InDepth  = zasp_pkg::InQueueDepth,
  parameter int unsigned OutDepth = zasp_pkg::OutQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  byte_out_o,
  output logic [3:0]  byte_class_o,
  output logic        header_done_o,
  output logic        entry_end_o,
  output logic        is_compressed_o,
  output logic [31:0] uncompressed_size_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);
  import zasp_pkg::*;

  queue_status_t in_status, out_status;
  logic [7:0]    in_byte;
  logic          in_pop, out_push;
  result_t       core_result, out_result;

  // Front: input byte queue
  zasp_fifo #(
    .Width(8),
    .Depth(InDepth)
  ) u_in_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (data_byte_i),
    .pop_i    (in_pop),
    .rdata_o  (in_byte),
    .status_o (in_status)
  );

  // Middle: framing core
  zasp_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_status_i  (in_status),
    .in_byte_i    (in_byte),
    .in_pop_o     (in_pop),
    .out_status_i (out_status),
    .out_push_o   (out_push),
    .result_o     (core_result)
  );

  // Result queue
  zasp_fifo #(
    .Width($bits(result_t)),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (out_push),
    .wdata_i  (core_result),
    .pop_i    (pop),
    .rdata_o  (out_result),
    .status_o (out_status)
  );

  assign full                = in_status.full;
  assign empty               = !out_status.not_empty;
  assign byte_out_o          = out_result.byte_out;
  assign byte_class_o        = out_result.byte_class;
  assign header_done_o       = out_result.header_done;
  assign entry_end_o         = out_result.entry_end;
  assign is_compressed_o     = out_result.is_compressed;
  assign uncompressed_size_o = out_result.uncompressed_size;
  assign status_o            = out_result.status;

endmodule
